@@ src/bsi_pkg.sv @@
// ----------------------------------------------------------------------------
// bsi_pkg: shared types and constants
// Item types and pipeline widths for the scanline intersection block.
// ----------------------------------------------------------------------------
package bsi_pkg;

  localparam int SQRT_STAGES = 30;
  localparam int RAD_W       = 60;
  localparam int ROOT_W      = 30;
  localparam int TQ_W        = 17;
  localparam int DIV_W       = 52;
  localparam int NUM_W       = 34;
  localparam int TOT_W       = 58;

  typedef struct packed {
    logic signed [15:0] scan_y;
    logic               is_quadratic;
    logic signed [15:0] p0_x;
    logic signed [15:0] p0_y;
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
  } in_item_t;

  typedef struct packed {
    logic               first_hit;
    logic signed [23:0] first_x;
    logic               second_hit;
    logic signed [23:0] second_x;
  } out_item_t;

  // curve terms carried alongside the root pipeline
  typedef struct packed {
    logic               valid;
    logic               quad;
    logic               dneg;
    logic signed [16:0] a;
    logic signed [18:0] b;
    logic signed [16:0] c;
    logic signed [15:0] x0;
    logic signed [16:0] ex;
    logic signed [18:0] fx;
  } side_t;

  // terms carried alongside the divider pipeline
  typedef struct packed {
    logic               valid;
    logic               quad;
    logic               hit1;
    logic               hit2;
    logic signed [15:0] x0;
    logic signed [16:0] ex;
    logic signed [18:0] fx;
  } xside_t;

endpackage

@@ src/bsi_if.sv @@
// ----------------------------------------------------------------------------
// bsi_in_if / bsi_out_if: valid-ready channels
// Carry curve items into the block and crossing results out of it.
// ----------------------------------------------------------------------------
interface bsi_in_if;
  logic               valid;
  logic               ready;
  bsi_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsi_out_if;
  logic               valid;
  logic               ready;
  bsi_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/bsi_isqrt.sv @@
// ----------------------------------------------------------------------------
// bsi_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(rad)), advances when en is high.
// ----------------------------------------------------------------------------
module bsi_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bsi_pkg::RAD_W-1:0]   rad,
  output logic [bsi_pkg::ROOT_W-1:0]  root
);
  import bsi_pkg::*;

  logic [RAD_W-1:0] v   [SQRT_STAGES+1];
  logic [RAD_W-1:0] res [SQRT_STAGES+1];

  assign v[0]   = rad;
  assign res[0] = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v[k] >= trial) begin
          v[k+1]   <= v[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          v[k+1]   <= v[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign root = res[SQRT_STAGES][ROOT_W-1:0];

endmodule

@@ src/bsi_div.sv @@
// ----------------------------------------------------------------------------
// bsi_div: pipelined restoring divider
// Quotient of num by den, one quotient bit per stage, quotient below 2^TQ_W.
// ----------------------------------------------------------------------------
module bsi_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bsi_pkg::DIV_W-1:0] num,
  input  logic [bsi_pkg::DIV_W-1:0] den,
  output logic [bsi_pkg::TQ_W-1:0]  quo
);
  import bsi_pkg::*;

  logic [DIV_W-1:0] r [TQ_W+1];
  logic [DIV_W-1:0] d [TQ_W+1];
  logic [TQ_W-1:0]  q [TQ_W+1];

  assign r[0] = num;
  assign d[0] = den;
  assign q[0] = '0;

  for (genvar k = 0; k < TQ_W; k++) begin : g_stage
    localparam int SH = TQ_W - 1 - k;
    logic [DIV_W-1:0] dsh;
    assign dsh = d[k] << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        d[k+1] <= d[k];
        if (r[k] >= dsh) begin
          r[k+1] <= r[k] - dsh;
          q[k+1] <= q[k] | (TQ_W'(1) << SH);
        end else begin
          r[k+1] <= r[k];
          q[k+1] <= q[k];
        end
      end
    end
  end

  assign quo = q[TQ_W];

endmodule

@@ src/bezier_scanline_intersect.sv @@
// ----------------------------------------------------------------------------
// bezier_scanline_intersect: scanline crossings of a line or quadratic curve
// Pipeline: 3 setup stages, 30 root stages, 2 setup stages for the ratio,
// 17 divider stages, 2 multiply stages and the output register.
// Throughput one item per cycle; the whole pipeline holds while a result
// waits. Synchronous reset clears all stage valid bits.
// ----------------------------------------------------------------------------
module bezier_scanline_intersect (
  input  logic       clk,
  input  logic       rst,
  bsi_in_if.sink     item_in,
  bsi_out_if.source  result_out
);
  import bsi_pkg::*;

  logic en;
  logic out_v;
  out_item_t res_q;

  assign en             = !out_v || result_out.ready;
  assign item_in.ready  = en;
  assign result_out.valid = out_v;
  assign result_out.data  = res_q;

  // stage 1: curve terms
  side_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (en) begin
      s1.valid <= item_in.valid;
      s1.quad  <= item_in.data.is_quadratic;
      s1.dneg  <= 1'b0;
      s1.a     <= 17'(item_in.data.p0_y) - 17'(item_in.data.p1_y);
      s1.b     <= 19'(item_in.data.p0_y) - (19'(item_in.data.p1_y) <<< 1)
                  + 19'(item_in.data.p2_y);
      s1.c     <= 17'(item_in.data.p0_y) - 17'(item_in.data.scan_y);
      s1.x0    <= item_in.data.p0_x;
      s1.ex    <= 17'(item_in.data.p1_x) - 17'(item_in.data.p0_x);
      s1.fx    <= item_in.data.is_quadratic ?
                  19'(item_in.data.p0_x) - (19'(item_in.data.p1_x) <<< 1)
                  + 19'(item_in.data.p2_x) : '0;
    end
  end

  // stage 2: products of the discriminant
  side_t s2;
  logic signed [34:0] aa;
  logic signed [36:0] bc;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (en) begin
      s2 <= s1;
      aa <= s1.a * s1.a;
      bc <= s1.b * s1.c;
    end
  end

  // stage 3: discriminant and radicand
  side_t s3, s3_next;
  logic [RAD_W-1:0] rad;
  logic signed [37:0] disc;
  assign disc = 38'(aa) - 38'(bc);

  always_comb begin
    s3_next      = s2;
    s3_next.dneg = disc[37];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else if (en) begin
      s3      <= s3_next;
      rad     <= disc[37] ? '0 : RAD_W'(disc[35:0]) << 24;
    end
  end

  logic [ROOT_W-1:0] root;
  bsi_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  side_t sp [SQRT_STAGES+1];
  assign sp[0] = s3;
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqside
    always_ff @(posedge clk) begin
      if (rst) begin
        sp[k+1] <= '0;
      end else if (en) begin
        sp[k+1] <= sp[k];
      end
    end
  end

  side_t sq;
  assign sq = sp[SQRT_STAGES];

  // stage 4: ratio operands for both roots
  xside_t x4;
  logic signed [NUM_W-1:0] num1, num2, den4;
  logic ok1, ok2;
  always_ff @(posedge clk) begin
    if (rst) begin
      x4 <= '0;
    end else if (en) begin
      x4.valid <= sq.valid;
      x4.quad  <= sq.quad;
      x4.hit1  <= 1'b0;
      x4.hit2  <= 1'b0;
      x4.x0    <= sq.x0;
      x4.ex    <= sq.ex;
      x4.fx    <= sq.fx;
      if (sq.quad && sq.b != '0) begin
        den4 <= NUM_W'(sq.b) <<< 12;
        num1 <= (NUM_W'(sq.a) <<< 12) - $signed(NUM_W'(root));
        num2 <= (NUM_W'(sq.a) <<< 12) + $signed(NUM_W'(root));
        ok1  <= !sq.dneg;
        ok2  <= !sq.dneg;
      end else begin
        // line, or degenerate quadratic solved as c / (2a)
        den4 <= sq.quad ? NUM_W'(sq.a) <<< 1 : NUM_W'(sq.a);
        num1 <= NUM_W'(sq.c);
        num2 <= '0;
        ok1  <= 1'b1;
        ok2  <= 1'b0;
      end
    end
  end

  // stage 5: sign fix, range test, divider operands
  logic signed [NUM_W-1:0] den_n, n1_n, n2_n;
  logic h1, h2;
  assign den_n = den4[NUM_W-1] ? -den4 : den4;
  assign n1_n  = den4[NUM_W-1] ? -num1 : num1;
  assign n2_n  = den4[NUM_W-1] ? -num2 : num2;
  assign h1 = ok1 && (den4 != '0) && !n1_n[NUM_W-1] && (n1_n <= den_n);
  assign h2 = ok2 && (den4 != '0) && !n2_n[NUM_W-1] && (n2_n <= den_n);

  xside_t x5, x5_next;
  logic [DIV_W-1:0] dn1, dn2, dd;

  always_comb begin
    x5_next      = x4;
    x5_next.hit1 = h1;
    x5_next.hit2 = h2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x5 <= '0;
    end else if (en) begin
      x5      <= x5_next;
      dn1     <= h1 ? (DIV_W'(unsigned'(n1_n)) << TQ_W) + DIV_W'(unsigned'(den_n)) : '0;
      dn2     <= h2 ? (DIV_W'(unsigned'(n2_n)) << TQ_W) + DIV_W'(unsigned'(den_n)) : '0;
      dd      <= DIV_W'(unsigned'(den_n)) << 1;
    end
  end

  logic [TQ_W-1:0] tq1, tq2;
  bsi_div u_div1 (.clk(clk), .en(en), .num(dn1), .den(dd), .quo(tq1));
  bsi_div u_div2 (.clk(clk), .en(en), .num(dn2), .den(dd), .quo(tq2));

  xside_t xp [TQ_W+1];
  assign xp[0] = x5;
  for (genvar k = 0; k < TQ_W; k++) begin : g_dvside
    always_ff @(posedge clk) begin
      if (rst) begin
        xp[k+1] <= '0;
      end else if (en) begin
        xp[k+1] <= xp[k];
      end
    end
  end

  xside_t xd;
  assign xd = xp[TQ_W];

  // stage 6: t squared and t times the first difference
  xside_t x6;
  logic [2*TQ_W-1:0] tt1, tt2;
  logic signed [35:0] m1, m2;
  always_ff @(posedge clk) begin
    if (rst) begin
      x6 <= '0;
    end else if (en) begin
      x6  <= xd;
      tt1 <= tq1 * tq1;
      tt2 <= tq2 * tq2;
      m1  <= $signed({1'b0, tq1}) * xd.ex;
      m2  <= $signed({1'b0, tq2}) * xd.ex;
    end
  end

  // stage 7: t squared times the second difference
  xside_t x7;
  logic signed [54:0] p1, p2;
  logic signed [35:0] m1q, m2q;
  always_ff @(posedge clk) begin
    if (rst) begin
      x7 <= '0;
    end else if (en) begin
      x7  <= x6;
      p1  <= $signed({1'b0, tt1}) * x6.fx;
      p2  <= $signed({1'b0, tt2}) * x6.fx;
      m1q <= m1;
      m2q <= m2;
    end
  end

  // output stage: sum in Q32 of t, round to Q8
  logic signed [TOT_W-1:0] base, tot1, tot2, r1, r2;
  assign base = TOT_W'(x7.x0) <<< 32;
  assign tot1 = base + (x7.quad ? TOT_W'(m1q) <<< 17 : TOT_W'(m1q) <<< 16) + TOT_W'(p1);
  assign tot2 = base + (x7.quad ? TOT_W'(m2q) <<< 17 : TOT_W'(m2q) <<< 16) + TOT_W'(p2);
  assign r1 = tot1 + (TOT_W'(1) <<< 23);
  assign r2 = tot2 + (TOT_W'(1) <<< 23);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= x7.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q.first_hit  <= x7.hit1;
      res_q.first_x    <= x7.hit1 ? r1[47:24] : '0;
      res_q.second_hit <= x7.hit2;
      res_q.second_x   <= x7.hit2 ? r2[47:24] : '0;
    end
  end

endmodule
